// ----- hw/rtl/amc_pkg.sv -----
// shared types and constants for the accumulator machine core
`timescale 1ns / 1ps

package amc_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_EXEC    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic [15:0] OP_HLT = 16'd0;
  localparam logic [15:0] OP_IN  = 16'd1;
  localparam logic [15:0] OP_OUT = 16'd2;
  localparam logic [15:0] OP_LDA = 16'd3;
  localparam logic [15:0] OP_STA = 16'd4;
  localparam logic [15:0] OP_ADD = 16'd5;
  localparam logic [15:0] OP_SUB = 16'd6;
  localparam logic [15:0] OP_INC = 16'd7;
  localparam logic [15:0] OP_DEC = 16'd8;
  localparam logic [15:0] OP_JMP = 16'd9;
  localparam logic [15:0] OP_JZ  = 16'd10;
  localparam logic [15:0] OP_JN  = 16'd11;
  localparam logic [15:0] OP_LIT = 16'd12;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [9:0]  code_addr;
    logic signed [15:0] code_word;
    logic signed [15:0] in_value;
  } cmd_t;

  typedef struct packed {
    logic               out_valid;
    logic signed [15:0] out_value;
    logic               in_taken;
    logic               halted;
    logic        [9:0]  prog_counter;
    logic signed [15:0] acc_value;
    logic        [31:0] cycle_count;
  } res_t;

endpackage

// ----- hw/rtl/accumulator_machine_core.sv -----
// accumulator machine core: code store, data store and one-instruction execute stage
// an accepted command word is registered in stage 1, then its result word in res; res_stall can hold both
// code writes, restarts and idle steps go one per cycle unless res_stall holds; an execute is not taken
//   while an execute, write or restart is in stage 1, as the code store rereads opcode and operand after one
// reset: control state clears, then a pass over every data store address zeroes the data store
//   with cmd_stall held high
`timescale 1ns / 1ps

module accumulator_machine_core #(
  parameter int CODE_DEPTH = 1024,
  parameter int MEM_DEPTH  = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  amc_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output amc_pkg::res_t res
);

  import amc_pkg::*;

  localparam int CW = $clog2(CODE_DEPTH);
  localparam int MW = $clog2(MEM_DEPTH);

  localparam logic [16:0] CD  = 17'(CODE_DEPTH);
  localparam logic [16:0] MD  = 17'(MEM_DEPTH);
  localparam logic [CW:0] CDW = (CW + 1)'(CODE_DEPTH);

  // reciprocals for exact floor division of 16-bit values
  localparam logic [32:0] RC =
    33'(((64'd1 << 32) + 64'(CODE_DEPTH) - 64'd1) / 64'(CODE_DEPTH));
  localparam logic [32:0] RM =
    33'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH));

  typedef struct packed {
    logic [15:0]   word;
    logic [CW-1:0] tgt;
    logic [MW-1:0] m;
  } code_ent_t;

  function automatic logic [15:0] mod_fix(input logic [15:0] x, input logic [48:0] p,
                                          input logic [16:0] d);
    logic [15:0] q;
    logic [32:0] qd;
    q  = p[47:32];
    qd = {17'b0, q} * {16'b0, d};
    return x - qd[15:0];
  endfunction

  // control and architectural state
  logic          clearing;
  logic [MW-1:0] clr_idx;
  logic          s1_v;
  cmd_t          s1_cmd;
  logic [48:0]   s1_pw_c;
  logic [48:0]   s1_pw_m;
  logic [48:0]   s1_pa_c;
  logic [CW-1:0] pc;
  logic [15:0]   acc;
  logic [31:0]   cnt;
  logic          halt;

  // memories
  code_ent_t     code_mem [CODE_DEPTH];
  code_ent_t     rd0;
  code_ent_t     rd1;
  logic [15:0]   data_mem [MEM_DEPTH];
  logic [15:0]   dq;

  // combinational
  logic          s1_go;
  logic          s1_free;
  logic          s1_exec_ok;
  logic          cmd_exec;
  logic          accept;
  logic [CW:0]   sum1;
  logic [CW:0]   sum2;
  logic [CW-1:0] pc_inc1;
  logic [CW-1:0] pc_inc2;
  logic [CW-1:0] pc_next;
  logic [15:0]   acc_next;
  logic [31:0]   cnt_next;
  logic          halt_next;
  logic          emit;
  logic          took;
  logic          dwe;
  logic [15:0]   dwd;
  logic          mem_we;
  logic [MW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          cwe;
  logic [CW-1:0] cwa;
  code_ent_t     cwd;
  logic          code_re;
  logic [CW:0]   rsum;
  logic [CW-1:0] ra0;
  logic [CW-1:0] ra1;
  res_t          res_next;

  assign cmd_exec   = (cmd.action == ACT_EXEC);
  assign s1_go      = s1_v && (!res_valid || !res_stall);
  assign s1_free    = !s1_v || s1_go;
  assign s1_exec_ok = !s1_v || (s1_go && s1_cmd.action == ACT_NONE);
  assign cmd_stall  = clearing || (cmd_exec ? !s1_exec_ok : !s1_free);
  assign accept     = cmd_valid && !cmd_stall;

  assign sum1    = {1'b0, pc} + (CW + 1)'(1);
  assign sum2    = {1'b0, pc} + (CW + 1)'(2);
  assign pc_inc1 = (sum1 >= CDW) ? CW'(sum1 - CDW) : CW'(sum1);
  assign pc_inc2 = (sum2 >= CDW) ? CW'(sum2 - CDW) : CW'(sum2);

  // code write entry with precomputed address wraps
  assign cwa      = CW'(mod_fix({6'b0, s1_cmd.code_addr}, s1_pa_c, CD));
  assign cwd.word = s1_cmd.code_word;
  assign cwd.tgt  = CW'(mod_fix(s1_cmd.code_word, s1_pw_c, CD));
  assign cwd.m    = MW'(mod_fix(s1_cmd.code_word, s1_pw_m, MD));

  always_comb begin
    pc_next   = pc;
    acc_next  = acc;
    cnt_next  = cnt;
    halt_next = halt;
    emit      = 1'b0;
    took      = 1'b0;
    dwe       = 1'b0;
    dwd       = acc;
    cwe       = 1'b0;
    code_re   = clearing;
    if (s1_go) begin
      unique case (s1_cmd.action)
        ACT_LOAD: begin
          cwe = 1'b1;
        end
        ACT_EXEC: begin
          code_re = 1'b1;
          if (!halt) begin
            cnt_next = cnt + 32'd1;
            pc_next  = pc_inc2;
            unique case (rd0.word)
              OP_IN: begin
                acc_next = s1_cmd.in_value;
                took     = 1'b1;
              end
              OP_OUT: emit = 1'b1;
              OP_LDA: acc_next = dq;
              OP_STA: dwe = 1'b1;
              OP_ADD: acc_next = acc + dq;
              OP_SUB: acc_next = acc - dq;
              OP_INC: begin
                dwe = 1'b1;
                dwd = dq + 16'd1;
              end
              OP_DEC: begin
                dwe = 1'b1;
                dwd = dq - 16'd1;
              end
              OP_JMP: pc_next = rd1.tgt;
              OP_JZ:  pc_next = (acc == 16'd0) ? rd1.tgt : pc_inc2;
              OP_JN:  pc_next = acc[15] ? rd1.tgt : pc_inc2;
              OP_LIT: acc_next = rd1.word;
              default: begin
                halt_next = 1'b1;
                pc_next   = pc;
              end
            endcase
          end
        end
        ACT_RESTART: begin
          code_re   = 1'b1;
          pc_next   = '0;
          acc_next  = '0;
          cnt_next  = '0;
          halt_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign rsum = {1'b0, pc_next} + (CW + 1)'(1);
  assign ra0  = pc_next;
  assign ra1  = (rsum >= CDW) ? CW'(rsum - CDW) : CW'(rsum);

  assign mem_we = clearing || dwe;
  assign mem_wa = clearing ? clr_idx : rd1.m;
  assign mem_wd = clearing ? 16'd0 : dwd;

  always_comb begin
    res_next.out_valid    = emit;
    res_next.out_value    = emit ? acc : 16'd0;
    res_next.in_taken     = took;
    res_next.halted       = halt_next;
    res_next.prog_counter = 10'(pc_next);
    res_next.acc_value    = acc_next;
    res_next.cycle_count  = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      s1_v      <= 1'b0;
      res_valid <= 1'b0;
      pc        <= '0;
      acc       <= '0;
      cnt       <= '0;
      halt      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + MW'(1);
        if (clr_idx == MW'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_v      <= accept || (s1_v && !s1_go);
      res_valid <= s1_go || (res_valid && res_stall);
      pc        <= pc_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      halt      <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_pw_c <= {33'b0, cmd.code_word} * {16'b0, RC};
      s1_pw_m <= {33'b0, cmd.code_word} * {16'b0, RM};
      s1_pa_c <= {39'b0, cmd.code_addr} * {16'b0, RC};
    end
    if (s1_go) begin
      res <= res_next;
    end
  end

  // code store, two registered read ports that track writes to pc and pc+1
  always_ff @(posedge clk) begin
    if (cwe) begin
      code_mem[cwa] <= cwd;
    end
    if (code_re) begin
      rd0 <= code_mem[ra0];
      rd1 <= code_mem[ra1];
    end else if (cwe) begin
      if (cwa == pc) begin
        rd0 <= cwd;
      end
      if (cwa == pc_inc1) begin
        rd1 <= cwd;
      end
    end
  end

  // data store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[mem_wa] <= mem_wd;
    end
    if (accept && cmd_exec) begin
      dq <= data_mem[rd1.m];
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_cmd.action == ACT_RESTART) |=>
      (pc == '0 && acc == '0 && cnt == '0 && !halt))
    else $error("restart did not clear machine state");

  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (halt && !(s1_go && s1_cmd.action == ACT_RESTART)) |=> halt)
    else $error("halt flag dropped without restart");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_cmd.action == ACT_EXEC && !halt) |=> (cnt == $past(cnt) + 32'd1))
    else $error("executed instruction not counted");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_go))
    else $error("result word without a completed command");

endmodule
